// ===== rtl/core/svd_pkg.sv =====
// shared types, constants and register codes for the staircase vertex detector
// no dependencies
`default_nettype none

package svd_pkg;

    localparam int NORMAL_BITS = 16;
    localparam int INDEX_BITS  = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int FRAC    = NORMAL_BITS - 1;
    localparam int MIS_W   = NORMAL_BITS;
    localparam int PROD_W  = 2 * NORMAL_BITS;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DOT_W   = 2 * FRAC + 1;
    localparam int CMP_W   = (MIS_W > CFG_W) ? MIS_W : CFG_W;
    localparam int LANES   = 3;

    typedef logic signed [NORMAL_BITS-1:0] t_norm;
    typedef logic        [NORMAL_BITS-1:0] t_norm_u;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [SUM_W-1:0]       t_sum_u;
    typedef logic        [DOT_W:0]         t_dotx;
    typedef logic        [MIS_W-1:0]       t_mis;
    typedef logic        [LANES-1:0][MIS_W-1:0] t_mis3;
    typedef logic        [INDEX_BITS-1:0]  t_index;
    typedef logic        [CFG_W-1:0]       t_cfg;
    typedef logic        [CMP_W-1:0]       t_cmp;

    // lane order of the misalignment values
    localparam int LANE_Z = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_X = 2;

    localparam t_mis   ONE_Q  = t_mis'(1) << FRAC;
    localparam t_dotx  ONE_Q2 = t_dotx'(1) << (2 * FRAC);
    localparam t_dotx  HALF_Q = t_dotx'(1) << (FRAC - 1);
    localparam t_sum_u ONE_Q2_S = t_sum_u'(1) << (2 * FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIENT_X  = 2'd0,
        CFG_ORIENT_Y  = 2'd1,
        CFG_ORIENT_Z  = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_idx;

    localparam t_cfg ORIENT_X_RST  = t_cfg'(0);
    localparam t_cfg ORIENT_Y_RST  = t_cfg'(0);
    localparam t_cfg ORIENT_Z_RST  = t_cfg'(32767);
    localparam t_cfg THRESHOLD_RST = t_cfg'(16384);

    // load enables of the two misalignment stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

    // a register value read as a normal-width component
    function automatic t_norm orient_norm(input t_cfg v);
        t_norm_u r;
        r = t_norm_u'(v);
        return t_norm'(r);
    endfunction

    // one minus the saturated magnitude of an axis component
    function automatic t_mis mis_axis(input t_norm c);
        t_norm_u a;
        a = c[NORMAL_BITS-1] ? t_norm_u'(-c) : t_norm_u'(c);
        if (t_mis'(a) > ONE_Q) begin
            a = t_norm_u'(ONE_Q);
        end
        return ONE_Q - t_mis'(a);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/svd_misalign.sv =====
// two-stage misalignment unit: products and axis terms, then the rounded dot term
// depends on svd_pkg
`default_nettype none

module svd_misalign (
    input  wire                 i_clk,
    input  svd_pkg::t_stage_en  i_en,
    input  svd_pkg::t_norm      i_nx,
    input  svd_pkg::t_norm      i_ny,
    input  svd_pkg::t_norm      i_nz,
    input  svd_pkg::t_cfg       i_ox,
    input  svd_pkg::t_cfg       i_oy,
    input  svd_pkg::t_cfg       i_oz,
    output svd_pkg::t_mis3      o_mis
);

    svd_pkg::t_prod  r_prod_x;
    svd_pkg::t_prod  r_prod_y;
    svd_pkg::t_prod  r_prod_z;
    svd_pkg::t_mis   r_mis_x2;
    svd_pkg::t_mis   r_mis_y2;
    svd_pkg::t_mis3  r_mis;

    svd_pkg::t_sum   s_sum;
    svd_pkg::t_sum_u s_abs;
    svd_pkg::t_dotx  s_dot;
    svd_pkg::t_dotx  s_mis_z_full;
    svd_pkg::t_mis   n_mis_z;

    // stage 2: three products in parallel, plus the x and y axis terms
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod_x <= svd_pkg::t_prod'(i_nx) * svd_pkg::t_prod'(svd_pkg::orient_norm(i_ox));
            r_prod_y <= svd_pkg::t_prod'(i_ny) * svd_pkg::t_prod'(svd_pkg::orient_norm(i_oy));
            r_prod_z <= svd_pkg::t_prod'(i_nz) * svd_pkg::t_prod'(svd_pkg::orient_norm(i_oz));
            r_mis_x2 <= svd_pkg::mis_axis(i_nx);
            r_mis_y2 <= svd_pkg::mis_axis(i_ny);
        end
    end

    // stage 3: sum, magnitude, saturate, round to the output format
    always_comb begin
        s_sum = svd_pkg::t_sum'(r_prod_x) + svd_pkg::t_sum'(r_prod_y)
              + svd_pkg::t_sum'(r_prod_z);
        s_abs = s_sum[svd_pkg::SUM_W-1] ? svd_pkg::t_sum_u'(-s_sum) : svd_pkg::t_sum_u'(s_sum);
        if (s_abs > svd_pkg::ONE_Q2_S) begin
            s_dot = svd_pkg::ONE_Q2;
        end else begin
            s_dot = svd_pkg::t_dotx'(s_abs);
        end
        s_mis_z_full = svd_pkg::ONE_Q2 - s_dot + svd_pkg::HALF_Q;
        n_mis_z      = s_mis_z_full[svd_pkg::FRAC +: svd_pkg::MIS_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_mis[svd_pkg::LANE_Z] <= n_mis_z;
            r_mis[svd_pkg::LANE_Y] <= r_mis_y2;
            r_mis[svd_pkg::LANE_X] <= r_mis_x2;
        end
    end

    assign o_mis = r_mis;

endmodule

`default_nettype wire

// ===== rtl/core/svd_accum.sv =====
// per-vertex min/max tracking, spread test, vertex counter and result register
// depends on svd_pkg
`default_nettype none

module svd_accum (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire                 i_last,
    input  wire                 i_none,
    input  svd_pkg::t_mis3      i_mis,
    input  svd_pkg::t_cfg       i_threshold,
    input  wire                 i_ready,
    output logic                o_valid,
    output svd_pkg::t_index     o_vertex_index,
    output logic                o_is_artifact,
    output svd_pkg::t_index     o_count
);

    svd_pkg::t_mis3  r_min;
    svd_pkg::t_mis3  r_max;
    logic            r_open;
    svd_pkg::t_index r_count;
    logic            r_out_vld;
    svd_pkg::t_index r_out_idx;
    logic            r_out_art;

    svd_pkg::t_mis3  n_min;
    svd_pkg::t_mis3  n_max;
    logic            n_hit;
    svd_pkg::t_mis   s_spread;
    logic            s_emit;

    always_comb begin
        n_hit = 1'b0;
        for (int i = 0; i < svd_pkg::LANES; i++) begin
            if (!r_open) begin
                n_min[i] = i_mis[i];
                n_max[i] = i_mis[i];
            end else begin
                n_min[i] = (i_mis[i] < r_min[i]) ? i_mis[i] : r_min[i];
                n_max[i] = (i_mis[i] > r_max[i]) ? i_mis[i] : r_max[i];
            end
            s_spread = n_max[i] - n_min[i];
            if (svd_pkg::t_cmp'(s_spread) >= svd_pkg::t_cmp'(i_threshold)) begin
                n_hit = 1'b1;
            end
        end
    end

    assign s_emit = i_adv && (i_last || i_none);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= '0;
            r_max     <= '0;
            r_open    <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_adv) begin
                if (i_none || i_last) begin
                    r_open  <= 1'b0;
                    r_count <= r_count + 1'b1;
                end else begin
                    r_open <= 1'b1;
                end
                if (!i_none) begin
                    r_min <= n_min;
                    r_max <= n_max;
                end
            end
            if (s_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_idx <= r_count;
            r_out_art <= i_none || n_hit;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_vertex_index = r_out_idx;
    assign o_is_artifact  = r_out_art;
    assign o_count        = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/staircase_vertex_detector.sv =====
// top level of the staircase vertex detector: input stage, config registers,
// stage control, assertions; depends on svd_pkg, svd_misalign, svd_accum
`default_nettype none

// Takes one face normal per transfer and classifies a vertex on its last face
// (or on a no_faces item, which is always flagged). One item is accepted every
// cycle while the result channel does not stall; a result appears on o_valid
// after the input register, product stage, dot-term stage and result register.
// The rate is set by the per-vertex min/max update in the accumulator, which is
// combinational. Items that end no vertex give no result. Configuration writes
// take effect at the next edge and must only be made while the pipe is empty.
module staircase_vertex_detector (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // configuration write port
    input  wire                     i_cfg_we,
    input  wire [svd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [svd_pkg::CFG_W-1:0]     i_cfg_data,
    // face normal channel
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire signed [svd_pkg::NORMAL_BITS-1:0] i_normal_x,
    input  wire signed [svd_pkg::NORMAL_BITS-1:0] i_normal_y,
    input  wire signed [svd_pkg::NORMAL_BITS-1:0] i_normal_z,
    input  wire                     i_last_face,
    input  wire                     i_no_faces,
    // vertex result channel
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [svd_pkg::INDEX_BITS-1:0] o_vertex_index,
    output logic                    o_is_artifact
);

    // configuration registers
    svd_pkg::t_cfg r_orient_x;
    svd_pkg::t_cfg r_orient_y;
    svd_pkg::t_cfg r_orient_z;
    svd_pkg::t_cfg r_threshold;

    // stage 1: registered input transfer
    logic           r_s1_vld;
    svd_pkg::t_norm r_s1_nx;
    svd_pkg::t_norm r_s1_ny;
    svd_pkg::t_norm r_s1_nz;
    logic           r_s1_last;
    logic           r_s1_none;

    // side flags riding along with the misalignment stages
    logic           r_s2_vld;
    logic           r_s2_last;
    logic           r_s2_none;
    logic           r_s3_vld;
    logic           r_s3_last;
    logic           r_s3_none;

    svd_pkg::t_stage_en s_en;
    logic               s_en_out;
    logic               s_en1;
    logic               s_adv;
    svd_pkg::t_mis3     s_mis;
    svd_pkg::t_index    s_count;

    // each stage loads when it is empty or the one after it moves on
    assign s_en_out = !o_valid || i_ready;
    assign s_adv    = r_s3_vld && s_en_out;
    assign s_en.s3  = !r_s3_vld || s_en_out;
    assign s_en.s2  = !r_s2_vld || s_en.s3;
    assign s_en1    = !r_s1_vld || s_en.s2;
    assign o_ready  = s_en1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient_x  <= svd_pkg::ORIENT_X_RST;
            r_orient_y  <= svd_pkg::ORIENT_Y_RST;
            r_orient_z  <= svd_pkg::ORIENT_Z_RST;
            r_threshold <= svd_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (svd_pkg::t_cfg_idx'(i_cfg_idx))
                svd_pkg::CFG_ORIENT_X:  r_orient_x  <= i_cfg_data;
                svd_pkg::CFG_ORIENT_Y:  r_orient_y  <= i_cfg_data;
                svd_pkg::CFG_ORIENT_Z:  r_orient_z  <= i_cfg_data;
                svd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (s_en1) begin
                r_s1_vld <= i_valid;
            end
            if (s_en.s2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s_en.s3) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (s_en1) begin
            r_s1_nx   <= i_normal_x;
            r_s1_ny   <= i_normal_y;
            r_s1_nz   <= i_normal_z;
            r_s1_last <= i_last_face;
            r_s1_none <= i_no_faces;
        end
        if (s_en.s2) begin
            r_s2_last <= r_s1_last;
            r_s2_none <= r_s1_none;
        end
        if (s_en.s3) begin
            r_s3_last <= r_s2_last;
            r_s3_none <= r_s2_none;
        end
    end

    svd_misalign u_misalign (
        .i_clk (i_clk),
        .i_en  (s_en),
        .i_nx  (r_s1_nx),
        .i_ny  (r_s1_ny),
        .i_nz  (r_s1_nz),
        .i_ox  (r_orient_x),
        .i_oy  (r_orient_y),
        .i_oz  (r_orient_z),
        .o_mis (s_mis)
    );

    svd_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (s_adv),
        .i_last         (r_s3_last),
        .i_none         (r_s3_none),
        .i_mis          (s_mis),
        .i_threshold    (r_threshold),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_is_artifact  (o_is_artifact),
        .o_count        (s_count)
    );

    // the held result is always the vertex just before the running counter
    a_index_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vertex_index == s_count - 1'b1))
        else $error("result index out of step with vertex counter");

    // a vertex without faces is always flagged
    a_no_faces_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && r_s3_none) |=> (o_valid && o_is_artifact))
        else $error("no_faces vertex not flagged");

    // a zero threshold flags every closed vertex
    a_zero_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && r_s3_last && (r_threshold == '0)) |=> (o_valid && o_is_artifact))
        else $error("zero threshold left a vertex unflagged");

    // no item leaves the last stage while the result register is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !s_adv)
        else $error("item advanced into a stalled result register");

endmodule

`default_nettype wire
